FILE: design/array_list_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// Assert that a property holds at each rising clock edge outside reset.
`define ALE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Assert a property with reset included in the evaluation.
`define ALE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/ale_pkg.sv
// Package with commands, status codes and sizes of the list engine.
package ale_pkg;

  localparam int unsigned Capacity = 128;

  typedef enum logic [3:0] {
    OP_CLEAR   = 4'd0,
    OP_GET     = 4'd1,
    OP_LOCATE  = 4'd2,
    OP_PRIOR   = 4'd3,
    OP_NEXT    = 4'd4,
    OP_INSERT  = 4'd5,
    OP_DELETE  = 4'd6,
    OP_REVERSE = 4'd7,
    OP_ROTATE  = 4'd8
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SRCH,
    S_SHIFT,
    S_FLIPA,
    S_FLIPB,
    S_FLIPC,
    S_FLIPD,
    S_DONE
  } state_e;

endpackage

FILE: design/ale_store.sv
// Element store: one synchronous memory, one write and one read port.
module ale_store #(
  parameter int unsigned Capacity = ale_pkg::Capacity,
  localparam int unsigned AddrW   = $clog2(Capacity)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/array_list_engine.sv
// Top level of the array list engine.
// Keeps an ordered list of up to CAPACITY signed 32-bit elements in a single
// synchronous memory and serves one command per request, one at a time.
// Clear and bad requests go straight to the result; get, prior and next
// read one entry first. Locate reads one entry a cycle up to the first match;
// insert and delete move one entry a cycle over the tail, and insert then
// places the new value; reverse swaps one pair at a time through the states
// FLIPA to FLIPD; rotate is three reversals. The single memory port pair
// makes these steps serial. One result register holds the reply until taken;
// the next request is accepted once the result is delivered.
module array_list_engine #(
  parameter int unsigned CAPACITY = ale_pkg::Capacity,
  localparam int unsigned AddrW   = $clog2(CAPACITY),
  localparam int unsigned LenW    = $clog2(CAPACITY + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  opcode_i,
  input  logic [7:0]  position_i,
  input  logic signed [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [31:0] data_o,
  output logic [7:0]  found_index_o,
  output logic [7:0]  count_o,
  output logic        is_empty_o
);

  ale_pkg::state_e state_q, state_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [3:0]       op_q;
  logic [LenW-1:0]  pos_q;
  logic [31:0]      val_q;
  logic [LenW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [1:0]       pass_q, pass_d;
  logic [31:0]      tmp_q, tmp_d;
  logic [1:0]       st_q, st_d;
  logic [31:0]      dat_q, dat_d;
  logic [LenW-1:0]  fnd_q, fnd_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;

  ale_store #(.Capacity(CAPACITY)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic accept;
  assign in_ready_o  = (state_q == ale_pkg::S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ale_pkg::S_DONE);

  // position widened to compare with length
  logic [LenW+7:0] p_w, l_w;
  assign p_w = (LenW+8)'(position_i);
  assign l_w = (LenW+8)'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ale_pkg::S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      pos_q <= (p_w > l_w + 1) ? LenW'(0) : LenW'(position_i);
      val_q <= value_i;
    end
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    pass_q <= pass_d;
    tmp_q  <= tmp_d;
    st_q   <= st_d;
    dat_q  <= dat_d;
    fnd_q  <= fnd_d;
  end

  // Next state and datapath.
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    pass_d  = pass_q;
    tmp_d   = tmp_q;
    st_d    = st_q;
    dat_d   = dat_q;
    fnd_d   = fnd_q;
    we      = 1'b0;
    waddr   = AddrW'(lo_q);
    wdata   = rdata;
    raddr   = AddrW'(lo_q);
    case (state_q)
      ale_pkg::S_IDLE: begin
        if (accept) begin
          st_d    = ale_pkg::ST_OK;
          dat_d   = '0;
          fnd_d   = '0;
          state_d = ale_pkg::S_DONE;
          case (opcode_i)
            ale_pkg::OP_CLEAR: len_d = '0;
            ale_pkg::OP_GET, ale_pkg::OP_DELETE: begin
              if (p_w >= 1 && p_w <= l_w) begin
                raddr   = AddrW'(position_i - 8'd1);
                lo_d    = LenW'(position_i - 8'd1);
                state_d = ale_pkg::S_READ;
              end else st_d = ale_pkg::ST_BAD;
            end
            ale_pkg::OP_PRIOR: begin
              if (p_w >= 2 && p_w <= l_w) begin
                raddr   = AddrW'(position_i - 8'd2);
                state_d = ale_pkg::S_READ;
              end else st_d = ale_pkg::ST_BAD;
            end
            ale_pkg::OP_NEXT: begin
              if (p_w >= 1 && p_w < l_w) begin
                raddr   = AddrW'(position_i);
                state_d = ale_pkg::S_READ;
              end else st_d = ale_pkg::ST_BAD;
            end
            ale_pkg::OP_LOCATE: begin
              if (len_q != 0) begin
                raddr   = '0;
                lo_d    = '0;
                state_d = ale_pkg::S_SRCH;
              end
            end
            ale_pkg::OP_INSERT: begin
              if (p_w < 1 || p_w > l_w + 1) st_d = ale_pkg::ST_BAD;
              else if (len_q >= LenW'(CAPACITY)) st_d = ale_pkg::ST_FULL;
              else begin
                // walk down from the top, moving each entry up one
                hi_d    = len_q;
                raddr   = AddrW'(len_q - 1'b1);
                state_d = ale_pkg::S_SHIFT;
              end
            end
            ale_pkg::OP_REVERSE: begin
              if (len_q > 1) begin
                lo_d    = '0;
                hi_d    = len_q - 1'b1;
                pass_d  = 2'd2;
                state_d = ale_pkg::S_FLIPA;
              end
            end
            ale_pkg::OP_ROTATE: begin
              if (p_w >= 1 && p_w < l_w) begin
                lo_d    = '0;
                hi_d    = LenW'(position_i - 8'd1);
                pass_d  = 2'd0;
                state_d = ale_pkg::S_FLIPA;
              end else st_d = ale_pkg::ST_BAD;
            end
            default: st_d = ale_pkg::ST_BAD;
          endcase
        end
      end
      ale_pkg::S_READ: begin
        dat_d = rdata;
        if (op_q == ale_pkg::OP_DELETE) begin
          lo_d    = lo_q;
          raddr   = AddrW'(lo_q + 1'b1);
          state_d = (lo_q + 1'b1 < len_q) ? ale_pkg::S_SHIFT : ale_pkg::S_DONE;
          if (lo_q + 1'b1 >= len_q) len_d = len_q - 1'b1;
        end else state_d = ale_pkg::S_DONE;
      end
      ale_pkg::S_SRCH: begin
        if (rdata == val_q) begin
          fnd_d   = lo_q + 1'b1;
          state_d = ale_pkg::S_DONE;
        end else if (lo_q + 1'b1 >= len_q) state_d = ale_pkg::S_DONE;
        else begin
          lo_d  = lo_q + 1'b1;
          raddr = AddrW'(lo_q + 1'b1);
        end
      end
      ale_pkg::S_SHIFT: begin
        if (op_q == ale_pkg::OP_INSERT) begin
          // rdata holds entry hi-1; place the new value once the gap is open
          if (hi_q < pos_q) begin
            we      = 1'b1;
            waddr   = AddrW'(pos_q - 1'b1);
            wdata   = val_q;
            len_d   = len_q + 1'b1;
            state_d = ale_pkg::S_DONE;
          end else begin
            we    = 1'b1;
            waddr = AddrW'(hi_q);
            wdata = rdata;
            hi_d  = hi_q - 1'b1;
            raddr = AddrW'(hi_q - 2'd2);
          end
        end else begin
          // delete: rdata holds entry lo+1
          we    = 1'b1;
          waddr = AddrW'(lo_q);
          wdata = rdata;
          if (lo_q + 2'd2 >= len_q) begin
            len_d   = len_q - 1'b1;
            state_d = ale_pkg::S_DONE;
          end else begin
            lo_d  = lo_q + 1'b1;
            raddr = AddrW'(lo_q + 2'd2);
          end
        end
      end
      ale_pkg::S_FLIPA: begin
        if (lo_q < hi_q) begin
          raddr   = AddrW'(lo_q);
          state_d = ale_pkg::S_FLIPB;
        end else if (pass_q == 2'd0) begin
          lo_d   = pos_q;
          hi_d   = len_q - 1'b1;
          pass_d = 2'd1;
        end else if (pass_q == 2'd1) begin
          lo_d   = '0;
          hi_d   = len_q - 1'b1;
          pass_d = 2'd2;
        end else state_d = ale_pkg::S_DONE;
      end
      ale_pkg::S_FLIPB: begin
        tmp_d   = rdata;
        raddr   = AddrW'(hi_q);
        state_d = ale_pkg::S_FLIPC;
      end
      ale_pkg::S_FLIPC: begin
        we      = 1'b1;
        waddr   = AddrW'(lo_q);
        wdata   = rdata;
        state_d = ale_pkg::S_FLIPD;
      end
      ale_pkg::S_FLIPD: begin
        we      = 1'b1;
        waddr   = AddrW'(hi_q);
        wdata   = tmp_q;
        lo_d    = lo_q + 1'b1;
        hi_d    = hi_q - 1'b1;
        state_d = ale_pkg::S_FLIPA;
      end
      ale_pkg::S_DONE: begin
        if (out_ready_i) state_d = ale_pkg::S_IDLE;
      end
      default: state_d = ale_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    status_o      = st_q;
    data_o        = dat_q;
    found_index_o = 8'(fnd_q);
    count_o       = 8'(len_q);
    is_empty_o    = (len_q == '0);
  end

endmodule

FILE: design/ale_checker.sv
// Port-level checker for the list engine, bound to the top level.
`include "array_list_engine_assert.svh"

module ale_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [7:0]  count_o,
  input logic        is_empty_o
);

  `ALE_ASSERT(a_empty_flag, is_empty_o == (count_o == 8'd0), "empty flag mismatch")
  `ALE_ASSERT(a_one_at_a_time, !(in_ready_o && out_valid_o), "request taken while result pending")
  `ALE_ASSERT(a_status_code, out_valid_o |-> (status_o != 2'd3), "bad status code")
  `ALE_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(count_o)), "result dropped")
  `ALE_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")

endmodule

bind array_list_engine ale_checker u_ale_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .status_o   (status_o),
  .count_o    (count_o),
  .is_empty_o (is_empty_o)
);

FILE: dv/array_list_engine_test.sv
// Self-checking testbench for the array list engine: directed table, fill to capacity, then random traffic.
`timescale 1ns / 100ps

module array_list_engine_test;

  localparam int unsigned Cap = ale_pkg::Capacity;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned NumRandom = 500;

  typedef struct packed {
    logic [3:0]         op;
    logic [7:0]         pos;
    logic signed [31:0] val;
  } request_t;

  typedef struct packed {
    ale_pkg::status_e   status;
    logic signed [31:0] data;
    logic [7:0]         found;
    logic [7:0]         count;
    logic               empty;
  } reply_t;

  typedef struct {
    request_t req;
    logic     typed;
    reply_t   rep;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] opcode_i = '0;
  logic [7:0] position_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic signed [31:0] data_o;
  logic [7:0] found_index_o;
  logic [7:0] count_o;
  logic is_empty_o;

  array_list_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .position_i, .value_i,
    .out_valid_o, .out_ready_i, .status_o, .data_o, .found_index_o, .count_o, .is_empty_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the list.
  logic signed [31:0] shadow_list [Cap];
  int unsigned shadow_len = 0;
  reply_t replies_due [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit hold_off = 1'b0;

  function automatic void flip_list(int lo, int hi);
    logic signed [31:0] t;
    while (lo < hi) begin
      t = shadow_list[lo];
      shadow_list[lo] = shadow_list[hi];
      shadow_list[hi] = t;
      lo++;
      hi--;
    end
  endfunction

  function automatic reply_t apply_command(request_t r);
    reply_t o;
    int unsigned p;
    int unsigned len;
    p = r.pos;
    len = shadow_len;
    o = '{status: ale_pkg::ST_OK, data: '0, found: '0, count: '0, empty: 1'b0};
    case (r.op)
      ale_pkg::OP_CLEAR: shadow_len = 0;
      ale_pkg::OP_GET: begin
        if (p >= 1 && p <= len) o.data = shadow_list[p-1];
        else o.status = ale_pkg::ST_BAD;
      end
      ale_pkg::OP_LOCATE: begin
        for (int k = 0; k < len; k++) begin
          if (shadow_list[k] == r.val) begin
            o.found = 8'(k + 1);
            break;
          end
        end
      end
      ale_pkg::OP_PRIOR: begin
        if (p >= 2 && p <= len) o.data = shadow_list[p-2];
        else o.status = ale_pkg::ST_BAD;
      end
      ale_pkg::OP_NEXT: begin
        if (p >= 1 && p < len) o.data = shadow_list[p];
        else o.status = ale_pkg::ST_BAD;
      end
      ale_pkg::OP_INSERT: begin
        if (p < 1 || p > len + 1) o.status = ale_pkg::ST_BAD;
        else if (len >= Cap) o.status = ale_pkg::ST_FULL;
        else begin
          for (int k = len; k >= int'(p); k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = r.val;
          shadow_len = len + 1;
        end
      end
      ale_pkg::OP_DELETE: begin
        if (p >= 1 && p <= len) begin
          o.data = shadow_list[p-1];
          for (int k = p - 1; k + 1 < len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len = len - 1;
        end else o.status = ale_pkg::ST_BAD;
      end
      ale_pkg::OP_REVERSE: if (len > 1) flip_list(0, len - 1);
      ale_pkg::OP_ROTATE: begin
        if (p >= 1 && p < len) begin
          flip_list(0, p - 1);
          flip_list(p, len - 1);
          flip_list(0, len - 1);
        end else o.status = ale_pkg::ST_BAD;
      end
      default: o.status = ale_pkg::ST_BAD;
    endcase
    o.count = 8'(shadow_len);
    o.empty = (shadow_len == 0);
    return o;
  endfunction

  // Drive one request at the falling edge and hold until accepted.
  task automatic send_request(request_t r, logic typed, reply_t typed_rep);
    reply_t pred;
    pred = apply_command(r);
    if (typed && pred != typed_rep) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: op %0d pos %0d", r.op, r.pos);
    end
    replies_due.push_back(pred);
    opcode_i <= r.op;
    position_i <= r.pos;
    value_i <= r.val;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.val = $urandom();
    if ($urandom_range(0, 3) == 0 && shadow_len > 0)
      r.val = shadow_list[$urandom_range(0, shadow_len - 1)];
    if (pick < 35) r.op = ale_pkg::OP_INSERT;
    else if (pick < 45) r.op = ale_pkg::OP_DELETE;
    else if (pick < 55) r.op = ale_pkg::OP_GET;
    else if (pick < 63) r.op = ale_pkg::OP_LOCATE;
    else if (pick < 70) r.op = ale_pkg::OP_PRIOR;
    else if (pick < 77) r.op = ale_pkg::OP_NEXT;
    else if (pick < 84) r.op = ale_pkg::OP_REVERSE;
    else if (pick < 93) r.op = ale_pkg::OP_ROTATE;
    else if (pick < 95) r.op = ale_pkg::OP_CLEAR;
    else r.op = 4'($urandom_range(0, 15));
    // Mostly legal positions, some anywhere in the field.
    if ($urandom_range(0, 9) < 8) r.pos = 8'($urandom_range(0, shadow_len + 1));
    else r.pos = 8'($urandom());
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("array_list_engine_test: errors");
      $finish;
    end
  end

  // Receiver: own stall pattern plus one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= (cycles % 13 < 9) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply status %0d", status_o);
      end else begin
        want = replies_due.pop_front();
        if (status_o != want.status || data_o != want.data || found_index_o != want.found
            || count_o != want.count || is_empty_o != want.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st %0d d %0d f %0d c %0d e %0d got st %0d d %0d f %0d c %0d e %0d",
                     want.status, want.data, want.found, want.count, want.empty,
                     status_o, data_o, found_index_o, count_o, is_empty_o);
        end
      end
    end
  end

  initial begin
    row_t table_rows [$];
    reply_t none;
    request_t r;
    none = '0;
    // Empty list: errors, then fill edges of values and positions.
    table_rows.push_back('{'{ale_pkg::OP_GET, 8'd1, 32'sd0}, 1'b1,
                           '{ale_pkg::ST_BAD, 32'sd0, 8'd0, 8'd0, 1'b1}});
    table_rows.push_back('{'{ale_pkg::OP_REVERSE, 8'd0, 32'sd0}, 1'b1,
                           '{ale_pkg::ST_OK, 32'sd0, 8'd0, 8'd0, 1'b1}});
    table_rows.push_back('{'{ale_pkg::OP_INSERT, 8'd0, 32'sd5}, 1'b1,
                           '{ale_pkg::ST_BAD, 32'sd0, 8'd0, 8'd0, 1'b1}});
    table_rows.push_back('{'{ale_pkg::OP_INSERT, 8'd1, 32'h7fffffff}, 1'b1,
                           '{ale_pkg::ST_OK, 32'sd0, 8'd0, 8'd1, 1'b0}});
    table_rows.push_back('{'{ale_pkg::OP_INSERT, 8'd1, 32'h80000000}, 1'b1,
                           '{ale_pkg::ST_OK, 32'sd0, 8'd0, 8'd2, 1'b0}});
    table_rows.push_back('{'{ale_pkg::OP_INSERT, 8'd3, -32'sd1}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_INSERT, 8'd4, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_INSERT, 8'd255, 32'sd9}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_GET, 8'd1, 32'sd0}, 1'b1,
                           '{ale_pkg::ST_OK, 32'h80000000, 8'd0, 8'd4, 1'b0}});
    table_rows.push_back('{'{ale_pkg::OP_LOCATE, 8'd0, -32'sd1}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_LOCATE, 8'd0, 32'sd77}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_PRIOR, 8'd1, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_PRIOR, 8'd4, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_NEXT, 8'd4, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_NEXT, 8'd3, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_REVERSE, 8'd0, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_ROTATE, 8'd4, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_ROTATE, 8'd1, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_ROTATE, 8'd3, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_DELETE, 8'd4, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{ale_pkg::OP_DELETE, 8'd9, 32'sd0}, 1'b0, none});
    table_rows.push_back('{'{4'd15, 8'd1, 32'sd0}, 1'b1,
                           '{ale_pkg::ST_BAD, 32'sd0, 8'd0, 8'd3, 1'b0}});
    table_rows.push_back('{'{ale_pkg::OP_CLEAR, 8'd0, 32'sd0}, 1'b1,
                           '{ale_pkg::ST_OK, 32'sd0, 8'd0, 8'd0, 1'b1}});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i]) begin
      send_request(table_rows[i].req, table_rows[i].typed, table_rows[i].rep);
      if (i % 4 == 3) idle_gap();
    end

    // Fill to capacity and hit full, with the receiver held off for a stretch.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i <= Cap; i++) begin
      r = '{ale_pkg::OP_INSERT, 8'($urandom_range(1, shadow_len + 1)), $urandom()};
      send_request(r, 1'b0, none);
    end
    r = '{ale_pkg::OP_INSERT, 8'd1, 32'sd3};
    send_request(r, 1'b1, '{ale_pkg::ST_FULL, 32'sd0, 8'd0, 8'(Cap), 1'b0});
    r = '{ale_pkg::OP_ROTATE, 8'(Cap - 1), 32'sd0};
    send_request(r, 1'b0, none);
    r = '{ale_pkg::OP_REVERSE, 8'd0, 32'sd0};
    send_request(r, 1'b0, none);
    r = '{ale_pkg::OP_LOCATE, 8'd0, shadow_list[Cap-1]};
    send_request(r, 1'b0, none);
    r = '{ale_pkg::OP_CLEAR, 8'd0, 32'sd0};
    send_request(r, 1'b0, none);

    // Random bursts; keep the list short most of the time.
    for (int n = 0; n < NumRandom; ) begin
      repeat ($urandom_range(1, 12)) begin
        if (n < NumRandom) begin
          r = random_request();
          if (shadow_len > 24 && r.op == ale_pkg::OP_INSERT && $urandom_range(0, 1))
            r.op = ale_pkg::OP_DELETE;
          send_request(r, 1'b0, none);
          n++;
        end
      end
      idle_gap();
    end
    in_valid_i <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) $display("array_list_engine_test: clean");
    else $display("array_list_engine_test: errors");
    $finish;
  end

endmodule
